// ===== design/ppi_pkg.sv =====
// Package for the planar pose integrator: payload structs, controller/datapath
// command and status types, multiplier widths and sine polynomial constants.
// No dependencies.
`default_nettype none

package ppi_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int POSITION_BITS_DEF = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_X       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_Y       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_HEADING = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME    = 2'd3;

    // shared multiplier: signed A x signed B
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // sine polynomial, Q.16
    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [16:0] SIN_B = 17'd42048;
    localparam logic [16:0] SIN_C = 17'd4640;

    typedef struct packed {
        logic signed [31:0] vel_fwd;
        logic signed [31:0] vel_side;
        logic signed [23:0] turn_rate;
    } ppi_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] heading;
    } ppi_out_t;

    typedef enum logic [3:0] {
        MO_NONE,
        MO_ZZ,
        MO_CZ,
        MO_TZ2,
        MO_TZ,
        MO_VF_SN,
        MO_VS_SN,
        MO_VF_CS,
        MO_VS_CS,
        MO_RX_DT,
        MO_RY_DT,
        MO_WR_DT
    } ppi_mop_t;

    typedef struct packed {
        logic     load;
        logic     update;
        ppi_mop_t mul_op;
        logic     mul_ch;
        ppi_mop_t wb_op;
        logic     wb_ch;
    } ppi_cmd_t;

    typedef struct packed {
        logic out_busy;
    } ppi_stat_t;

endpackage

`default_nettype wire

// ===== design/planar_pose_integrator_core.sv =====
// Planar pose integrator top level: controller plus datapath sharing one multiplier.
// Inputs are taken only in the idle state, so a new item is not accepted until the last is done.
// The single 34x18 multiplier forms 15 products in turn for each item.
// A waiting result holds only the final update step; the next item is not taken meanwhile.
// Reset (aresetn low, synchronous): pose and step time cleared to zero, no result pending.
`default_nettype none

module planar_pose_integrator_core
    import ppi_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire ppi_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output ppi_out_t                   m_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    ppi_cmd_t  cmd;
    ppi_stat_t stat;

    ppi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ppi_datapath #(
        .ANGLE_BITS    (ANGLE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in flight");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> !(m_valid && !m_ready))
        else $error("pose update overwrote a pending result");

    a_update_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> m_valid)
        else $error("pose update did not present a result");

endmodule

`default_nettype wire

// ===== design/ppi_ctrl.sv =====
// Pose integrator controller: one-hot sequencer that issues multiplier and
// writeback commands to the datapath. Depends on ppi_pkg.
`default_nettype none

module ppi_ctrl
    import ppi_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire ppi_stat_t stat,
    output ppi_cmd_t       cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SINE  = 6'b000010,
        ST_ROT   = 6'b000100,
        ST_SCALE = 6'b001000,
        ST_FLUSH = 6'b010000,
        ST_UPD   = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    ppi_mop_t   wb_op_reg;
    logic       wb_ch_reg;
    ppi_mop_t   mul_op;
    logic       mul_ch;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 3'd1;
        mul_op     = MO_NONE;
        mul_ch     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_valid) begin
                    state_next = ST_SINE;
                end
            end
            ST_SINE: begin
                mul_ch = cnt_reg[0];
                unique case (cnt_reg[2:1])
                    2'd0: mul_op = MO_ZZ;
                    2'd1: mul_op = MO_CZ;
                    2'd2: mul_op = MO_TZ2;
                    2'd3: mul_op = MO_TZ;
                    default: mul_op = MO_NONE;
                endcase
                if (cnt_reg == 3'd7) begin
                    state_next = ST_ROT;
                    cnt_next   = '0;
                end
            end
            ST_ROT: begin
                unique case (cnt_reg[1:0])
                    2'd0: mul_op = MO_VF_SN;
                    2'd1: mul_op = MO_VS_SN;
                    2'd2: mul_op = MO_VF_CS;
                    2'd3: mul_op = MO_VS_CS;
                    default: mul_op = MO_NONE;
                endcase
                if (cnt_reg[1:0] == 2'd3) begin
                    state_next = ST_SCALE;
                    cnt_next   = '0;
                end
            end
            ST_SCALE: begin
                unique case (cnt_reg[1:0])
                    2'd0: mul_op = MO_RX_DT;
                    2'd1: mul_op = MO_RY_DT;
                    default: mul_op = MO_WR_DT;
                endcase
                if (cnt_reg[1:0] == 2'd2) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (!stat.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            wb_op_reg <= MO_NONE;
            wb_ch_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            wb_op_reg <= mul_op;
            wb_ch_reg <= mul_ch;
        end
    end

    always_comb begin
        cmd.load   = s_valid && s_ready;
        cmd.update = (state_reg == ST_UPD) && !stat.out_busy;
        cmd.mul_op = mul_op;
        cmd.mul_ch = mul_ch;
        cmd.wb_op  = wb_op_reg;
        cmd.wb_ch  = wb_ch_reg;
    end

endmodule

`default_nettype wire

// ===== design/ppi_datapath.sv =====
// Pose integrator datapath: pose and step-time registers, sine/cosine chains,
// one shared multiplier with writeback, output register. Depends on ppi_pkg.
`default_nettype none

module ppi_datapath
    import ppi_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ppi_cmd_t              cmd,
    output ppi_stat_t                  stat,
    input  wire ppi_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output ppi_out_t                   m_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int QW   = ANGLE_BITS - 2;
    localparam int ZDN  = (ANGLE_BITS >= 18) ? ANGLE_BITS - 18 : 0;
    localparam int ZUP  = (ANGLE_BITS < 18) ? 18 - ANGLE_BITS : 0;
    localparam int SW   = ((POSITION_BITS > MUL_A_W) ? POSITION_BITS : MUL_A_W) + 1;
    localparam logic signed [SW-1:0] PMAX =
        {{(SW - POSITION_BITS + 1){1'b0}}, {(POSITION_BITS - 1){1'b1}}};
    localparam logic signed [SW-1:0] PMIN = ~PMAX;
    localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(32768);

    function automatic logic signed [POSITION_BITS-1:0] sat_pos(
        input logic signed [SW-1:0] v
    );
        logic signed [POSITION_BITS-1:0] r;
        priority if (v > PMAX) begin
            r = PMAX[POSITION_BITS-1:0];
        end else if (v < PMIN) begin
            r = PMIN[POSITION_BITS-1:0];
        end else begin
            r = v[POSITION_BITS-1:0];
        end
        return r;
    endfunction

    // pose state
    logic signed [POSITION_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [POSITION_BITS-1:0] cur_y_reg, cur_y_next;
    logic        [ANGLE_BITS-1:0]    cur_h_reg, cur_h_next;
    logic        [15:0]              dt_reg, dt_next;
    logic                            m_valid_reg, m_valid_next;
    ppi_out_t                        out_reg;

    // work registers
    logic signed [31:0]        vf_reg, vs_reg;
    logic signed [23:0]        wr_reg;
    logic        [1:0]         quad_reg [2];
    logic        [16:0]        z_reg    [2];
    logic        [16:0]        z2_reg   [2];
    logic        [16:0]        t_reg    [2];
    logic signed [MUL_B_W-1:0] sc_reg   [2];
    logic        [PROD_W-1:0]  acc_x_reg, acc_y_reg;
    logic signed [MUL_A_W-1:0] rx_reg, ry_reg, dx_reg, dy_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic        [QW-1:0]      frac;
    logic        [15:0]        z16;
    logic        [1:0]         quad_s, quad_c;
    logic        [16:0]        z_s, z_c;
    logic        [16:0]        p_hi;
    logic        [PROD_W:0]    sum_x, sum_y;
    logic        [PROD_W-1:0]  rnd_p;
    logic signed [SW-1:0]      sx, sy;

    // angle reduction for both chains
    always_comb begin
        frac   = cur_h_reg[QW-1:0];
        z16    = 16'(({16'b0, frac} >> ZDN) << ZUP);
        quad_s = cur_h_reg[ANGLE_BITS-1 -: 2];
        quad_c = quad_s + 2'd1;
        z_s    = quad_s[0] ? 17'h10000 - {1'b0, z16} : {1'b0, z16};
        z_c    = quad_c[0] ? 17'h10000 - {1'b0, z16} : {1'b0, z16};
    end

    // operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_op)
            MO_ZZ: begin
                mul_a = {{(MUL_A_W-17){1'b0}}, z_reg[cmd.mul_ch]};
                mul_b = {1'b0, z_reg[cmd.mul_ch]};
            end
            MO_CZ: begin
                mul_a = {{(MUL_A_W-17){1'b0}}, SIN_C};
                mul_b = {1'b0, z2_reg[cmd.mul_ch]};
            end
            MO_TZ2: begin
                mul_a = {{(MUL_A_W-17){1'b0}}, t_reg[cmd.mul_ch]};
                mul_b = {1'b0, z2_reg[cmd.mul_ch]};
            end
            MO_TZ: begin
                mul_a = {{(MUL_A_W-17){1'b0}}, t_reg[cmd.mul_ch]};
                mul_b = {1'b0, z_reg[cmd.mul_ch]};
            end
            MO_VF_SN: begin
                mul_a = {{(MUL_A_W-32){vf_reg[31]}}, vf_reg};
                mul_b = sc_reg[0];
            end
            MO_VS_SN: begin
                mul_a = {{(MUL_A_W-32){vs_reg[31]}}, vs_reg};
                mul_b = sc_reg[0];
            end
            MO_VF_CS: begin
                mul_a = {{(MUL_A_W-32){vf_reg[31]}}, vf_reg};
                mul_b = sc_reg[1];
            end
            MO_VS_CS: begin
                mul_a = {{(MUL_A_W-32){vs_reg[31]}}, vs_reg};
                mul_b = sc_reg[1];
            end
            MO_RX_DT: begin
                mul_a = rx_reg;
                mul_b = {2'b00, dt_reg};
            end
            MO_RY_DT: begin
                mul_a = ry_reg;
                mul_b = {2'b00, dt_reg};
            end
            MO_WR_DT: begin
                mul_a = {{(MUL_A_W-24){wr_reg[23]}}, wr_reg};
                mul_b = {2'b00, dt_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // writeback arithmetic on the registered product
    always_comb begin
        p_hi  = prod_reg[32:16];
        sum_x = {prod_reg[PROD_W-1], prod_reg} - {acc_x_reg[PROD_W-1], acc_x_reg} + HALF;
        sum_y = {prod_reg[PROD_W-1], prod_reg} + {acc_y_reg[PROD_W-1], acc_y_reg} + HALF;
        rnd_p = prod_reg + HALF[PROD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load) begin
            vf_reg      <= s_data.vel_fwd;
            vs_reg      <= s_data.vel_side;
            wr_reg      <= s_data.turn_rate;
            quad_reg[0] <= quad_s;
            quad_reg[1] <= quad_c;
            z_reg[0]    <= z_s;
            z_reg[1]    <= z_c;
        end
        unique case (cmd.wb_op)
            MO_ZZ:    z2_reg[cmd.wb_ch] <= p_hi;
            MO_CZ:    t_reg[cmd.wb_ch]  <= SIN_B - p_hi;
            MO_TZ2:   t_reg[cmd.wb_ch]  <= SIN_A - p_hi;
            MO_TZ:    sc_reg[cmd.wb_ch] <= quad_reg[cmd.wb_ch][1] ? -$signed({1'b0, p_hi})
                                                                  : $signed({1'b0, p_hi});
            MO_VF_SN: acc_y_reg <= prod_reg;
            MO_VS_SN: acc_x_reg <= prod_reg;
            MO_VF_CS: rx_reg    <= sum_x[16 +: MUL_A_W];
            MO_VS_CS: ry_reg    <= sum_y[16 +: MUL_A_W];
            MO_RX_DT: dx_reg    <= rnd_p[16 +: MUL_A_W];
            MO_RY_DT: dy_reg    <= rnd_p[16 +: MUL_A_W];
            default: ;
        endcase
    end

    // pose update, configuration and output register
    always_comb begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        cur_h_next   = cur_h_reg;
        dt_next      = dt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        sx = SW'(cur_x_reg) + SW'(dx_reg);
        sy = SW'(cur_y_reg) + SW'(dy_reg);
        if (cmd.wb_op == MO_WR_DT) begin
            cur_h_next = cur_h_reg + rnd_p[16 +: ANGLE_BITS];
        end
        if (cmd.update) begin
            cur_x_next   = sat_pos(sx);
            cur_y_next   = sat_pos(sy);
            m_valid_next = 1'b1;
        end
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_INIT_X:       cur_x_next = sat_pos(SW'($signed(cfg_wdata)));
                CFG_INIT_Y:       cur_y_next = sat_pos(SW'($signed(cfg_wdata)));
                CFG_INIT_HEADING: cur_h_next = ANGLE_BITS'(cfg_wdata[15:0]);
                CFG_STEP_TIME:    dt_next    = cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            cur_h_reg   <= '0;
            dt_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            cur_h_reg   <= cur_h_next;
            dt_reg      <= dt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            out_reg.pos_x   <= 32'(cur_x_next);
            out_reg.pos_y   <= 32'(cur_y_next);
            out_reg.heading <= 16'(cur_h_reg);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data        = out_reg;
    assign stat.out_busy = m_valid_reg && !m_ready;

endmodule

`default_nettype wire
